// ===== rtl/gcgs_pkg.sv =====
// Shared constants, register codes and interface types of the cost grid spreader.
`default_nettype none
package gcgs_pkg;
    // fixed field and datapath widths
    localparam int LVL_W      = 20;
    localparam int T_W        = 24;
    localparam int RES_W      = 17;
    localparam int SIGMA_W    = 24;
    localparam int RES2_W     = 34;
    localparam int B_W        = 49;
    localparam int REM_W      = 54;
    localparam int LOG_W      = 21;
    localparam int COST_W     = 15;
    localparam int Q_W        = 21;
    localparam int G_W        = 33;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [COST_W-1:0]  COST_OBSTACLE = 15'd25600;
    localparam logic [SIGMA_W-1:0] SIGMA_FLOOR   = 24'd655;
    localparam logic [15:0]        LN2_Q16       = 16'd45426;
    // ceil(2^17 / 3), exact division by three for values below 2^17
    localparam logic [16:0]        RECIP3        = 17'd43691;

    // opcodes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_MARK   = 2'd1;
    localparam logic [1:0] OP_SPREAD = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BY_LOG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_T      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RES    = 3'd5;

    typedef struct packed {
        logic [LVL_W-1:0] lvl_one;
        logic [LVL_W-1:0] lvl_two;
        logic [LVL_W-1:0] lvl_three;
        logic             by_log;
        logic [T_W-1:0]   t_param;
        logic [RES_W-1:0] res;
    } t_sigma_cfg;

    typedef struct packed {
        logic [RES2_W-1:0] res2;
        logic [B_W-1:0]    b;
    } t_coef;
endpackage
`default_nettype wire

// ===== rtl/gcgs_grid_mem.sv =====
// Cost grid storage: one write port, one registered read port.
`default_nettype none
module gcgs_grid_mem #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [14:0]       i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [14:0]       o_rdata
);
    logic [14:0] r_mem [DEPTH];
    logic [14:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== rtl/gcgs_setup.sv =====
// Per-spread setup: sigma (fixed or log scaled), radius, res^2 and 2*sigma^2.
`default_nettype none
module gcgs_setup #(
    parameter int MAX_RADIUS = 31,
    parameter int RAD_W      = $clog2(MAX_RADIUS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [1:0]            i_score,
    input  gcgs_pkg::t_sigma_cfg  i_cfg,
    output logic                  o_done,
    output logic [RAD_W-1:0]      o_radius,
    output gcgs_pkg::t_coef       o_coef
);
    import gcgs_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NORM = 3'd1;
    localparam logic [2:0] S_SQ   = 3'd2;
    localparam logic [2:0] S_LN   = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_PROD = 3'd5;
    localparam logic [2:0] S_RAD  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]         r_state;
    logic [30:0]        r_m;
    logic [4:0]         r_e;
    logic [15:0]        r_frac;
    logic [3:0]         r_cnt;
    logic               r_which;
    logic [LOG_W-1:0]   r_ls;
    logic [LOG_W-1:0]   r_lt;
    logic [21:0]        r_ln;
    logic [LVL_W-1:0]   r_base;
    logic [SIGMA_W-1:0] r_sigma;
    logic [RES_W-1:0]   r_res;
    logic [26:0]        r_acc;
    logic [25:0]        r_three;
    logic [RAD_W-1:0]   r_rad;
    t_coef              r_coef;

    logic [61:0]        w_sq;
    logic [31:0]        w_m2;
    logic [15:0]        w_frac_nx;
    logic [LOG_W-1:0]   w_log;
    logic [21:0]        w_num;
    logic [37:0]        w_lnp;
    logic [41:0]        w_sp;
    logic [SIGMA_W-1:0] w_s;
    logic [LVL_W-1:0]   w_base_sel;

    // log2 fraction step: square, renormalize
    assign w_sq      = 62'(r_m) * 62'(r_m);
    assign w_m2      = w_sq[61:30];
    assign w_frac_nx = {r_frac[14:0], w_m2[31]};
    assign w_log     = {r_e, w_frac_nx};

    // ln scaling and sigma product
    assign w_num = 22'(r_ls) + 22'h100000;
    assign w_lnp = 38'(w_num - 22'(r_lt)) * 38'(LN2_Q16);
    assign w_sp  = 42'(r_base) * 42'(r_ln);
    assign w_s   = w_sp[39:16];

    always_comb begin
        case (i_score)
            2'd1:    w_base_sel = i_cfg.lvl_one;
            2'd2:    w_base_sel = i_cfg.lvl_two;
            default: w_base_sel = i_cfg.lvl_three;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_base <= w_base_sel;
                        r_res  <= (i_cfg.res == '0) ? RES_W'(1) : i_cfg.res;
                        if (!i_cfg.by_log || i_cfg.t_param == '0) begin
                            r_sigma <= SIGMA_W'(w_base_sel);
                            r_state <= S_PROD;
                        end else begin
                            r_m     <= 31'(i_score);
                            r_e     <= 5'd30;
                            r_which <= 1'b0;
                            r_state <= S_NORM;
                        end
                    end
                end
                // shift the top set bit up to bit 30
                S_NORM: begin
                    if (r_m[30]) begin
                        r_cnt   <= '0;
                        r_frac  <= '0;
                        r_state <= S_SQ;
                    end else begin
                        r_m <= {r_m[29:0], 1'b0};
                        r_e <= r_e - 5'd1;
                    end
                end
                // sixteen fraction bits, one per square
                S_SQ: begin
                    r_frac <= w_frac_nx;
                    r_m    <= w_m2[31] ? w_m2[31:1] : w_m2[30:0];
                    r_cnt  <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        if (!r_which) begin
                            r_ls    <= w_log;
                            r_m     <= 31'(i_cfg.t_param);
                            r_e     <= 5'd30;
                            r_which <= 1'b1;
                            r_state <= S_NORM;
                        end else begin
                            r_lt    <= w_log;
                            r_state <= S_LN;
                        end
                    end
                end
                S_LN: begin
                    if (w_num <= 22'(r_lt)) begin
                        r_sigma <= SIGMA_FLOOR;
                        r_state <= S_PROD;
                    end else begin
                        r_ln    <= w_lnp[37:16];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_sigma <= (w_s < SIGMA_FLOOR) ? SIGMA_FLOOR : w_s;
                    r_state <= S_PROD;
                end
                // coefficients for the per-cell exponent
                S_PROD: begin
                    r_coef.res2 <= RES2_W'(r_res) * RES2_W'(r_res);
                    r_coef.b    <= {(48)'(r_sigma) * 48'(r_sigma), 1'b0};
                    r_three     <= {1'b0, r_sigma, 1'b0} + 26'(r_sigma);
                    r_acc       <= '0;
                    r_rad       <= '0;
                    r_state     <= S_RAD;
                end
                // radius = ceil(3 sigma / res), clamped
                S_RAD: begin
                    if (r_acc >= 27'(r_three) || r_rad == RAD_W'(MAX_RADIUS)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_acc <= r_acc + 27'(r_res);
                        r_rad <= r_rad + RAD_W'(1);
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = (r_state == S_DONE);
    assign o_radius = r_rad;
    assign o_coef   = r_coef;
endmodule
`default_nettype wire

// ===== rtl/gcgs_gauss.sv =====
// Per-cell cost: exponent by long division, Gaussian by repeated squaring.
`default_nettype none
module gcgs_gauss #(
    parameter int N_W = 11
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [N_W-1:0]       i_n,
    input  logic [1:0]           i_score,
    input  gcgs_pkg::t_coef      i_coef,
    output logic                 o_done,
    output logic [14:0]          o_cost
);
    import gcgs_pkg::*;

    localparam int A_W = N_W + RES2_W;

    localparam logic [2:0] G_IDLE = 3'd0;
    localparam logic [2:0] G_MUL  = 3'd1;
    localparam logic [2:0] G_CHK  = 3'd2;
    localparam logic [2:0] G_DIV  = 3'd3;
    localparam logic [2:0] G_SQ   = 3'd4;
    localparam logic [2:0] G_P    = 3'd5;
    localparam logic [2:0] G_T    = 3'd6;
    localparam logic [2:0] G_DONE = 3'd7;

    logic [2:0]        r_state;
    logic [A_W-1:0]    r_a;
    logic [REM_W-1:0]  r_rem;
    logic [B_W+3:0]    r_div;
    logic [Q_W-1:0]    r_q;
    logic [4:0]        r_cnt;
    logic [31:0]       r_y;
    logic [G_W-1:0]    r_g;
    logic [50:0]       r_p;
    logic [14:0]       r_cost;

    logic [REM_W-1:0]  w_wrk;
    logic              w_bit;
    logic [Q_W-1:0]    w_q_nx;
    logic [63:0]       w_ysq;
    logic [16:0]       w_k;
    logic [32:0]       w_t3;
    logic [15:0]       w_c;

    // one quotient bit per cycle: 5 integer steps, then 16 fraction steps
    assign w_wrk  = (r_cnt >= 5'd5) ? {r_rem[REM_W-2:0], 1'b0} : r_rem;
    assign w_bit  = (w_wrk >= REM_W'(r_div));
    assign w_q_nx = {r_q[Q_W-2:0], w_bit};
    assign w_ysq  = 64'(r_y) * 64'(r_y);
    assign w_k    = 17'(i_score) * 17'd25600;
    assign w_t3   = 33'(r_p[48:32]) * 33'(RECIP3);
    assign w_c    = w_t3[32:17];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
        end else begin
            case (r_state)
                G_IDLE: begin
                    if (i_start) begin
                        r_state <= G_MUL;
                    end
                end
                G_MUL: begin
                    r_a     <= A_W'(i_n) * A_W'(i_coef.res2);
                    r_state <= G_CHK;
                end
                // trivial exponents: zero distance, zero sigma, or 32 and above
                G_CHK: begin
                    if (r_a == '0) begin
                        r_g     <= {1'b1, 32'd0};
                        r_state <= G_P;
                    end else if (i_coef.b == '0 || REM_W'(r_a) >= {i_coef.b, 5'd0}) begin
                        r_g     <= '0;
                        r_state <= G_P;
                    end else begin
                        r_rem   <= REM_W'(r_a);
                        r_div   <= {i_coef.b, 4'd0};
                        r_q     <= '0;
                        r_cnt   <= '0;
                        r_state <= G_DIV;
                    end
                end
                G_DIV: begin
                    r_rem <= w_bit ? (w_wrk - REM_W'(r_div)) : w_wrk;
                    if (r_cnt < 5'd4) begin
                        r_div <= r_div >> 1;
                    end
                    r_q   <= w_q_nx;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd20) begin
                        r_cnt <= '0;
                        if (w_q_nx == '0) begin
                            r_g     <= {1'b1, 32'd0};
                            r_state <= G_P;
                        end else begin
                            r_y     <= 32'(33'h1_0000_0000 - 33'(w_q_nx));
                            r_state <= G_SQ;
                        end
                    end
                end
                // (1 - q/2^32)^(2^16)
                G_SQ: begin
                    r_y   <= w_ysq[63:32];
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd15) begin
                        r_g     <= {1'b0, w_ysq[63:32]};
                        r_state <= G_P;
                    end
                end
                // g * score * 25600 with rounding half
                G_P: begin
                    r_p     <= 51'(r_g) * 51'(w_k) + 51'h1_8000_0000;
                    r_state <= G_T;
                end
                G_T: begin
                    r_cost  <= (w_c > 16'(COST_OBSTACLE)) ? COST_OBSTACLE : w_c[14:0];
                    r_state <= G_DONE;
                end
                G_DONE: begin
                    r_state <= G_IDLE;
                end
                default: r_state <= G_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == G_DONE);
    assign o_cost = r_cost;
endmodule
`default_nettype wire

// ===== rtl/gaussian_cost_grid_spread.sv =====
// Reset and clear each sweep the grid to zero; the input is not ready meanwhile.
// Spread: setup of fixed sigma, or of log-scaled sigma (normalize and 16 squarings per
// logarithm), then the radius search, then every covered cell; in-grid cells run the
// serial divider and squaring loop, off-grid cells are skipped. One word at a time.
`default_nettype none
module gaussian_cost_grid_spread #(
    parameter int GRID_WIDTH  = 256,
    parameter int GRID_HEIGHT = 256,
    parameter int MAX_RADIUS  = 31
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_opcode,
    input  logic [7:0]                        i_cell_x,
    input  logic [7:0]                        i_cell_y,
    input  logic [1:0]                        i_hazard_score,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [14:0]                       o_cell_cost,
    output logic                              o_status,
    input  logic                              i_cfg_we,
    input  logic [gcgs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gcgs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import gcgs_pkg::*;

    localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
    localparam int D_W    = RAD_W + 1;
    localparam int N_W    = 2 * RAD_W + 1;
    localparam int CW     = $clog2(GRID_WIDTH + GRID_HEIGHT + 512 + MAX_RADIUS) + 1;

    localparam logic [3:0] T_CLR   = 4'd0;
    localparam logic [3:0] T_IDLE  = 4'd1;
    localparam logic [3:0] T_RD    = 4'd2;
    localparam logic [3:0] T_SETUP = 4'd3;
    localparam logic [3:0] T_CELL  = 4'd4;
    localparam logic [3:0] T_WAIT  = 4'd5;
    localparam logic [3:0] T_NEXT  = 4'd6;
    localparam logic [3:0] T_DONE  = 4'd7;

    // configuration
    t_sigma_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lvl_one   <= 20'd9830;
            r_cfg.lvl_two   <= 20'd13107;
            r_cfg.lvl_three <= 20'd16384;
            r_cfg.by_log    <= 1'b0;
            r_cfg.t_param   <= 24'd65536;
            r_cfg.res       <= 17'd3277;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIGMA1: r_cfg.lvl_one   <= i_cfg_data[LVL_W-1:0];
                CFG_SIGMA2: r_cfg.lvl_two   <= i_cfg_data[LVL_W-1:0];
                CFG_SIGMA3: r_cfg.lvl_three <= i_cfg_data[LVL_W-1:0];
                CFG_BY_LOG: r_cfg.by_log    <= i_cfg_data[0];
                CFG_T:      r_cfg.t_param   <= i_cfg_data[T_W-1:0];
                CFG_RES:    r_cfg.res       <= i_cfg_data[RES_W-1:0];
                default:    ;
            endcase
        end
    end

    logic [3:0]              r_state;
    logic [ADDR_W-1:0]       r_clr_addr;
    logic                    r_clr_item;
    logic [7:0]              r_cx;
    logic [7:0]              r_cy;
    logic [1:0]              r_score;
    logic signed [D_W-1:0]   r_dx;
    logic signed [D_W-1:0]   r_dy;
    logic [ADDR_W-1:0]       r_addr;
    logic [14:0]             r_item_cost;
    logic                    r_item_status;
    logic                    r_out_valid;
    logic [14:0]             r_out_cost;
    logic                    r_out_status;

    logic                    w_accept;
    logic                    w_in_inside;
    logic [ADDR_W-1:0]       w_in_addr;
    logic signed [CW-1:0]    w_gx;
    logic signed [CW-1:0]    w_gy;
    logic                    w_cell_inside;
    logic [ADDR_W-1:0]       w_cell_addr;
    logic [N_W-1:0]          w_n;
    logic signed [D_W-1:0]   w_pos_r;
    logic                    w_setup_start;
    logic                    w_setup_done;
    logic [RAD_W-1:0]        w_radius;
    t_coef                   w_coef;
    logic                    w_gauss_start;
    logic                    w_gauss_done;
    logic [14:0]             w_gauss_cost;
    logic                    w_we;
    logic [ADDR_W-1:0]       w_waddr;
    logic [14:0]             w_wdata;
    logic                    w_re;
    logic [ADDR_W-1:0]       w_raddr;
    logic [14:0]             w_rdata;
    logic                    w_upd;
    logic                    w_out_free;

    function automatic logic [ADDR_W-1:0] lin_addr(input logic [CW-1:0] x,
                                                   input logic [CW-1:0] y);
        logic [31:0] v;
        v = 32'(y) * 32'(GRID_WIDTH) + 32'(x);
        return v[ADDR_W-1:0];
    endfunction

    assign o_in_ready = (r_state == T_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // addressed cell of an incoming word
    assign w_in_inside = (32'(i_cell_x) < 32'(GRID_WIDTH)) &&
                         (32'(i_cell_y) < 32'(GRID_HEIGHT));
    assign w_in_addr   = lin_addr(CW'(i_cell_x), CW'(i_cell_y));

    // current cell of the spread sweep
    assign w_gx = signed'(CW'(r_cx)) + CW'(r_dx);
    assign w_gy = signed'(CW'(r_cy)) + CW'(r_dy);
    assign w_cell_inside = !w_gx[CW-1] && !w_gy[CW-1] &&
                           (w_gx < CW'(GRID_WIDTH)) && (w_gy < CW'(GRID_HEIGHT));
    assign w_cell_addr = lin_addr(unsigned'(w_gx), unsigned'(w_gy));
    assign w_n = unsigned'(N_W'(r_dx) * N_W'(r_dx) + N_W'(r_dy) * N_W'(r_dy));
    assign w_pos_r = signed'({1'b0, w_radius});

    assign w_setup_start = w_accept && (i_opcode == OP_SPREAD) && (i_hazard_score != 2'd0);
    assign w_gauss_start = (r_state == T_CELL) && w_cell_inside;
    assign w_upd = (w_rdata < COST_OBSTACLE) && (w_gauss_cost > w_rdata);
    assign w_out_free = !r_out_valid || i_out_ready;

    // memory port steering
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_addr;
        w_wdata = w_gauss_cost;
        w_re    = 1'b0;
        w_raddr = w_in_addr;
        case (r_state)
            T_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
            end
            T_IDLE: begin
                if (w_accept && w_in_inside && i_opcode == OP_MARK) begin
                    w_we    = 1'b1;
                    w_waddr = w_in_addr;
                    w_wdata = COST_OBSTACLE;
                end
                w_re = w_accept && w_in_inside && (i_opcode == OP_READ);
            end
            T_CELL: begin
                w_re    = w_cell_inside;
                w_raddr = w_cell_addr;
            end
            T_WAIT: begin
                w_we = w_gauss_done && w_upd;
            end
            default: ;
        endcase
    end

    // item sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= T_CLR;
            r_clr_addr <= '0;
            r_clr_item <= 1'b0;
        end else begin
            case (r_state)
                T_CLR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= r_clr_item ? T_DONE : T_IDLE;
                    end
                end
                T_IDLE: begin
                    if (w_accept) begin
                        r_cx          <= i_cell_x;
                        r_cy          <= i_cell_y;
                        r_score       <= i_hazard_score;
                        r_item_cost   <= '0;
                        r_item_status <= 1'b0;
                        case (i_opcode)
                            OP_CLEAR: begin
                                r_clr_addr <= '0;
                                r_clr_item <= 1'b1;
                                r_state    <= T_CLR;
                            end
                            OP_MARK: r_state <= T_DONE;
                            OP_SPREAD: begin
                                if (i_hazard_score == 2'd0) begin
                                    r_item_status <= 1'b1;
                                    r_state       <= T_DONE;
                                end else begin
                                    r_state <= T_SETUP;
                                end
                            end
                            default: r_state <= w_in_inside ? T_RD : T_DONE;
                        endcase
                    end
                end
                T_RD: begin
                    r_item_cost <= w_rdata;
                    r_state     <= T_DONE;
                end
                T_SETUP: begin
                    if (w_setup_done) begin
                        r_dx    <= -w_pos_r;
                        r_dy    <= -w_pos_r;
                        r_state <= T_CELL;
                    end
                end
                T_CELL: begin
                    r_addr  <= w_cell_addr;
                    r_state <= w_cell_inside ? T_WAIT : T_NEXT;
                end
                T_WAIT: begin
                    if (w_gauss_done) begin
                        r_state <= T_NEXT;
                    end
                end
                // dy inner, dx outer
                T_NEXT: begin
                    if (r_dy == w_pos_r) begin
                        if (r_dx == w_pos_r) begin
                            r_state <= T_DONE;
                        end else begin
                            r_dx    <= r_dx + D_W'(1);
                            r_dy    <= -w_pos_r;
                            r_state <= T_CELL;
                        end
                    end else begin
                        r_dy    <= r_dy + D_W'(1);
                        r_state <= T_CELL;
                    end
                end
                T_DONE: begin
                    if (w_out_free) begin
                        r_clr_item <= 1'b0;
                        r_state    <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == T_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == T_DONE && w_out_free) begin
            r_out_cost   <= r_item_cost;
            r_out_status <= r_item_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cell_cost = r_out_cost;
    assign o_status    = r_out_status;

    gcgs_setup #(
        .MAX_RADIUS (MAX_RADIUS),
        .RAD_W      (RAD_W)
    ) u_setup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_setup_start),
        .i_score  (i_hazard_score),
        .i_cfg    (r_cfg),
        .o_done   (w_setup_done),
        .o_radius (w_radius),
        .o_coef   (w_coef)
    );

    gcgs_gauss #(
        .N_W (N_W)
    ) u_gauss (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_gauss_start),
        .i_n     (w_n),
        .i_score (r_score),
        .i_coef  (w_coef),
        .o_done  (w_gauss_done),
        .o_cost  (w_gauss_cost)
    );

    gcgs_grid_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the Gaussian cost grid spreader.
`default_nettype none
module testbench;
    import gcgs_pkg::*;

    localparam int GRID_W         = 256;
    localparam int GRID_H         = 256;
    localparam int MAX_RAD        = 31;
    localparam int WATCHDOG_LIMIT = 1000000;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              status;
    } t_word_out;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic [1:0]            i_opcode       = OP_READ;
    logic [7:0]            i_cell_x       = '0;
    logic [7:0]            i_cell_y       = '0;
    logic [1:0]            i_hazard_score = '0;
    logic                  i_out_ready    = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = CFG_SIGMA1;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [14:0]           o_cell_cost;
    logic                  o_status;

    gaussian_cost_grid_spread #(
        .GRID_WIDTH (GRID_W),
        .GRID_HEIGHT(GRID_H),
        .MAX_RADIUS (MAX_RAD)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_cell_x      (i_cell_x),
        .i_cell_y      (i_cell_y),
        .i_hazard_score(i_hazard_score),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cell_cost   (o_cell_cost),
        .o_status      (o_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [COST_W-1:0] cost_map [0:GRID_W*GRID_H-1];
    logic [19:0]       sig_lvl [1:3];
    logic              sig_by_log;
    logic [23:0]       t_div;
    logic [16:0]       cell_res;

    t_word_out pending_costs[$];
    int        mismatches   = 0;
    int        words_in     = 0;
    int        words_out    = 0;
    int        spreads_done = 0;
    int        idle_cycles  = 0;
    int        out_hold     = 0;
    bit        calm         = 1'b0;
    int        last_cx      = 128;
    int        last_cy      = 128;

    // log2 in Q.16 by repeated squaring of the normalized mantissa
    function automatic longint unsigned log2_fixed(longint unsigned v);
        int unsigned     e;
        longint unsigned m;
        longint unsigned frac;
        e = 0;
        frac = 0;
        if (v == 0) return 0;
        while (e < 30 && (v >> (e + 1)) != 0) e++;
        m = v << (30 - e);
        for (int i = 0; i < 16; i++) begin
            frac = frac << 1;
            m = (m * m) >> 30;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | 64'd1;
            end
        end
        return (longint'(e) << 16) | frac;
    endfunction

    function automatic longint unsigned hazard_sigma(int score);
        longint unsigned base, num, den, ln, s;
        base = sig_lvl[score];
        if (!sig_by_log || t_div == 0) return base;
        num = log2_fixed(score) + (64'd16 << 16);
        den = log2_fixed(t_div);
        if (num <= den) return SIGMA_FLOOR;
        ln = ((num - den) * LN2_Q16) >> 16;
        s = (base * ln) >> 16;
        return (s < SIGMA_FLOOR) ? SIGMA_FLOOR : s;
    endfunction

    // exp(-a/b) in Q.32: (1 - q/2^32)^(2^16) with q = a/b in Q.16
    function automatic longint unsigned gauss_weight(longint unsigned a, longint unsigned b);
        longint unsigned ip, rem, q, y;
        if (a == 0) return 64'd1 << 32;
        if (b == 0) return 0;
        ip = a / b;
        if (ip >= 32) return 0;
        rem = a % b;
        q = ip;
        for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= b) begin
                rem = rem - b;
                q = q | 64'd1;
            end
        end
        if (q == 0) return 64'd1 << 32;
        y = (64'd1 << 32) - q;
        for (int i = 0; i < 16; i++) y = (y * y) >> 32;
        return y;
    endfunction

    task automatic spread_hazard(int cx, int cy, int score);
        longint unsigned res, sigma, r, b, n, g, cost;
        int gx, gy, rad;
        res = (cell_res != 0) ? cell_res : 1;
        sigma = hazard_sigma(score);
        r = (3 * sigma + res - 1) / res;
        b = 2 * sigma * sigma;
        if (r > MAX_RAD) r = MAX_RAD;
        rad = int'(r);
        for (int dx = -rad; dx <= rad; dx++) begin
            for (int dy = -rad; dy <= rad; dy++) begin
                gx = cx + dx;
                gy = cy + dy;
                if (gx < 0 || gy < 0 || gx >= GRID_W || gy >= GRID_H) continue;
                n = longint'(dx * dx + dy * dy);
                g = gauss_weight(n * res * res, b);
                cost = (g * score * COST_OBSTACLE + 3 * (64'd1 << 31)) / (64'd3 << 32);
                if (cost > COST_OBSTACLE) cost = COST_OBSTACLE;
                if (cost_map[gy*GRID_W+gx] < COST_OBSTACLE && cost > cost_map[gy*GRID_W+gx])
                    cost_map[gy*GRID_W+gx] = cost[COST_W-1:0];
            end
        end
    endtask

    // update the grid copy for one accepted word and queue its result
    task automatic predict_word(logic [1:0] op, int x, int y, int score);
        t_word_out w;
        w = '0;
        case (op)
            OP_CLEAR: begin
                foreach (cost_map[i]) cost_map[i] = '0;
            end
            OP_MARK: cost_map[y*GRID_W+x] = COST_OBSTACLE;
            OP_SPREAD: begin
                if (score == 0) w.status = 1'b1;
                else begin
                    spread_hazard(x, y, score);
                    spreads_done++;
                end
            end
            default: w.cost = cost_map[y*GRID_W+x];
        endcase
        pending_costs.insert(pending_costs.size(), w);
    endtask

    // send one word; valid stays up across back-to-back words
    task automatic send_word(logic [1:0] op, int x, int y, int score);
        i_in_valid     <= 1'b1;
        i_opcode       <= op;
        i_cell_x       <= x[7:0];
        i_cell_y       <= y[7:0];
        i_hazard_score <= score[1:0];
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        predict_word(op, x & 8'hFF, y & 8'hFF, score & 3);
        if (op == OP_SPREAD) begin
            last_cx = x & 8'hFF;
            last_cy = y & 8'hFF;
        end
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
    endtask

    // drain results and let the block settle before touching registers
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_costs.size() != 0 || !o_in_ready);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_settings(int s1, int s2, int s3, bit by_log, int t, int res);
        int vals[6];
        logic [CFG_IDX_W-1:0] idx[6];
        vals = '{s1, s2, s3, int'(by_log), t, res};
        idx  = '{CFG_SIGMA1, CFG_SIGMA2, CFG_SIGMA3, CFG_BY_LOG, CFG_T, CFG_RES};
        wait_idle();
        for (int i = 0; i < 6; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx[i];
            i_cfg_data <= vals[i][CFG_DATA_W-1:0];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        sig_lvl[1] = s1[19:0];
        sig_lvl[2] = s2[19:0];
        sig_lvl[3] = s3[19:0];
        sig_by_log = by_log;
        t_div      = t[23:0];
        cell_res   = res[16:0];
    endtask

    // result checker, receiver stalls and watchdog
    always @(posedge i_clk) begin
        t_word_out w;
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (i_in_valid && o_in_ready) words_in++;
        if (o_out_valid && i_out_ready) begin
            words_out++;
            if (pending_costs.size() == 0) begin
                $display("%0t: result with nothing expected: cost %0d status %0d",
                         $time, o_cell_cost, o_status);
                mismatches++;
            end else begin
                w = pending_costs[0];
                pending_costs.delete(0);
                if (o_cell_cost !== w.cost) begin
                    $display("%0t: cell_cost expected %0d actual %0d", $time, w.cost, o_cell_cost);
                    mismatches++;
                end
                if (o_status !== w.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, w.status, o_status);
                    mismatches++;
                end
            end
        end
        if (!i_rst_n) i_out_ready <= 1'b0;
        else if (calm) i_out_ready <= 1'b1;
        else if (out_hold > 0) begin
            out_hold--;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            out_hold = $urandom_range(0, 14);
            i_out_ready <= 1'b0;
        end else i_out_ready <= 1'b1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // obstacles, ignored score, overlap with default sigmas, clear
    task automatic test_basic_ops();
        send_word(OP_READ, 0, 0, 0);
        send_word(OP_MARK, 255, 255, 3);
        send_word(OP_READ, 255, 255, 0);
        send_word(OP_MARK, 129, 128, 0);
        send_word(OP_SPREAD, 170, 85, 0);
        send_word(OP_SPREAD, 128, 128, 3);
        send_word(OP_SPREAD, 128, 128, 1);
        send_word(OP_READ, 128, 128, 1);
        send_word(OP_READ, 129, 128, 2);
        send_word(OP_READ, 137, 131, 3);
        send_word(OP_SPREAD, 0, 255, 2);
        send_word(OP_READ, 1, 254, 0);
        send_word(OP_CLEAR, 85, 170, 2);
        send_word(OP_READ, 128, 128, 0);
    endtask

    // zero sigma with zero resolution: peak only, full peak turns into obstacle
    task automatic test_point_spread();
        apply_settings(0, 0, 0, 1'b0, 65536, 0);
        send_word(OP_SPREAD, 10, 10, 1);
        send_word(OP_READ, 10, 10, 0);
        send_word(OP_SPREAD, 10, 10, 3);
        send_word(OP_SPREAD, 10, 10, 2);
        send_word(OP_READ, 10, 10, 0);
        send_word(OP_READ, 11, 10, 0);
    endtask

    // widest sigma clamped to the largest radius; log mode with T zero falls back
    task automatic test_wide_spread();
        apply_settings(1048575, 1048575, 1048575, 1'b1, 0, 65536);
        send_word(OP_SPREAD, 0, 0, 3);
        send_word(OP_READ, 31, 0, 0);
        send_word(OP_READ, 20, 20, 0);
        send_word(OP_READ, 32, 32, 0);
    endtask

    // log mode with the largest T: sigma drops to the floor
    task automatic test_log_floor();
        apply_settings(1048575, 0, 3, 1'b1, 16777215, 655);
        send_word(OP_SPREAD, 50, 50, 1);
        send_word(OP_SPREAD, 60, 50, 3);
        send_word(OP_READ, 51, 50, 0);
        send_word(OP_READ, 60, 51, 0);
    endtask

    // random words: spreads with reads around recent centers and some marks
    task automatic run_random(int count);
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 8)
                send_word(OP_SPREAD, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 3));
            else if (pick < 17)
                send_word(OP_READ, last_cx + $urandom_range(0, 6) - 3,
                          last_cy + $urandom_range(0, 6) - 3, $urandom_range(0, 3));
            else
                send_word(OP_MARK, last_cx + $urandom_range(0, 4) - 2,
                          last_cy + $urandom_range(0, 4) - 2, $urandom_range(0, 3));
        end
    endtask

    task automatic test_random_fixed();
        int res;
        res = $urandom_range(32768, 65536);
        apply_settings($urandom_range(0, res / 2), $urandom_range(0, res / 2),
                       $urandom_range(0, res / 2), 1'b0, $urandom_range(0, 16777215), res);
        run_random(28);
    endtask

    task automatic test_random_log();
        int res;
        res = $urandom_range(32768, 65536);
        apply_settings($urandom_range(0, res / 24), $urandom_range(0, res / 24),
                       $urandom_range(0, res / 24), 1'b1, $urandom_range(0, 16777215), res);
        run_random(28);
        apply_settings($urandom_range(0, res / 32), $urandom_range(0, res / 32),
                       $urandom_range(0, res / 32), 1'b1, $urandom_range(1, 255), res);
        run_random(28);
    endtask

    // back-to-back traffic with both sides always ready
    task automatic test_random_calm();
        apply_settings($urandom_range(0, 20000), $urandom_range(0, 20000),
                       $urandom_range(0, 20000), 1'b0, 65536, 65536);
        calm = 1'b1;
        run_random(28);
    endtask

    initial begin
        foreach (cost_map[i]) cost_map[i] = '0;
        sig_lvl[1] = 20'd9830;
        sig_lvl[2] = 20'd13107;
        sig_lvl[3] = 20'd16384;
        sig_by_log = 1'b0;
        t_div      = 24'd65536;
        cell_res   = 17'd3277;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_point_spread();
        test_wide_spread();
        test_log_floor();
        test_random_fixed();
        test_random_log();
        test_random_calm();
        wait_idle();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d words, checked %0d results, %0d spreads over fixed, log and",
                 words_in, words_out, spreads_done);
        $display("floor sigma settings; %0d mismatches", mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
